@@ src/hsfc_pkg.sv @@
// Package for the half/single float converter: field widths, bit masks and
// operation codes. Used by every module of the converter; depends on nothing.
package hsfc_pkg;

    localparam int WordWidth = 32;
    localparam int HalfWidth = 16;
    localparam int HalfMantWidth = 10;
    localparam int HalfExpWidth = 5;
    localparam int SingleMantWidth = 23;
    localparam int SingleExpWidth = 8;

    // Single exponent fields at or below this underflow the half range.
    localparam logic [SingleExpWidth-1:0] S2H_EXP_LOW = 8'd112;
    // Single exponent fields at or above this overflow the half range.
    localparam logic [SingleExpWidth-1:0] S2H_EXP_HIGH = 8'd143;
    localparam logic [SingleExpWidth-1:0] S_EXP_ALL = 8'hFF;
    localparam logic [HalfExpWidth-1:0] H_EXP_ALL = 5'h1F;
    localparam logic [HalfMantWidth-1:0] H_QUIET = 10'h200;
    // Rebias from half (15) to single (127).
    localparam logic [SingleExpWidth-1:0] H2S_BIAS_ADJ = 8'd112;
    // Exponent of a half subnormal whose leading one sits at bit 0.
    localparam logic [SingleExpWidth-1:0] H2S_SUB_EXP_BASE = 8'd103;

    typedef enum logic
    {
        ACT_S2H = 1'b0,
        ACT_H2S = 1'b1
    } action_t;

endpackage

@@ src/hsfc_s2h.sv @@
// Single to half conversion: truncating, flush to zero, saturating to
// infinity, quiet NaN for NaN inputs. Pure logic; depends on hsfc_pkg.
module hsfc_s2h
(
    input  logic [hsfc_pkg::WordWidth-1:0] src,
    output logic [hsfc_pkg::HalfWidth-1:0] res
);

    logic                                    sign;
    logic [hsfc_pkg::SingleExpWidth-1:0]     efield;
    logic [hsfc_pkg::SingleMantWidth-1:0]    mant;
    logic [hsfc_pkg::SingleExpWidth-1:0]     ebias;

    assign sign   = src[31];
    assign efield = src[30:23];
    assign mant   = src[22:0];
    assign ebias  = efield - hsfc_pkg::S2H_EXP_LOW;

    always_comb
    begin
        if (efield <= hsfc_pkg::S2H_EXP_LOW)
        begin
            res = {sign, 15'd0};
        end
        else if (efield >= hsfc_pkg::S2H_EXP_HIGH)
        begin
            // Only a true NaN gets the quiet bit; finite overflow is infinity.
            if ((efield == hsfc_pkg::S_EXP_ALL) && (mant != '0))
                res = {sign, hsfc_pkg::H_EXP_ALL, hsfc_pkg::H_QUIET};
            else
                res = {sign, hsfc_pkg::H_EXP_ALL, 10'd0};
        end
        else
        begin
            res = {sign, ebias[hsfc_pkg::HalfExpWidth-1:0], mant[22:13]};
        end
    end

endmodule

@@ src/hsfc_h2s.sv @@
// Half to single conversion, exact: subnormals are normalized by a
// leading-one search, infinity and NaN payloads widened. Depends on hsfc_pkg.
module hsfc_h2s
(
    input  logic [hsfc_pkg::HalfWidth-1:0] src,
    output logic [hsfc_pkg::WordWidth-1:0] res
);

    logic                                  sign;
    logic [hsfc_pkg::HalfExpWidth-1:0]     efield;
    logic [hsfc_pkg::HalfMantWidth-1:0]    mant;
    logic [3:0]                            msb_pos;
    logic [3:0]                            shift;
    logic [hsfc_pkg::HalfMantWidth:0]      norm;
    logic [hsfc_pkg::SingleExpWidth-1:0]   sub_exp;
    logic [hsfc_pkg::SingleExpWidth-1:0]   norm_exp;

    assign sign   = src[15];
    assign efield = src[14:10];
    assign mant   = src[9:0];

    // Position of the leading one of the subnormal mantissa.
    always_comb
    begin
        msb_pos = 4'd0;
        for (int i = 0; i < hsfc_pkg::HalfMantWidth; i++)
        begin
            if (mant[i])
                msb_pos = 4'(i);
        end
    end

    assign shift    = 4'(hsfc_pkg::HalfMantWidth) - msb_pos;
    assign norm     = {1'b0, mant} << shift;
    assign sub_exp  = hsfc_pkg::H2S_SUB_EXP_BASE + {4'd0, msb_pos};
    assign norm_exp = {3'd0, efield} + hsfc_pkg::H2S_BIAS_ADJ;

    always_comb
    begin
        if (efield == '0)
        begin
            if (mant == '0)
                res = {sign, 31'd0};
            else
                res = {sign, sub_exp, norm[9:0], 13'd0};
        end
        else if (efield == hsfc_pkg::H_EXP_ALL)
        begin
            res = {sign, hsfc_pkg::S_EXP_ALL, mant, 13'd0};
        end
        else
        begin
            res = {sign, norm_exp, mant, 13'd0};
        end
    end

endmodule

@@ src/half_single_float_converter_top.sv @@
// Half/single float converter top level. An accepted word is captured in the
// input register, then its result and done are registered in the result register.
// Throughput: one word per cycle; busy is always low, the input register and
// the result register form a two-stage pipeline with no stall path.
// Reset: rst_n clears both stage valid flags asynchronously; no result strobes
// until a word has been accepted. Depends on hsfc_pkg, hsfc_s2h and hsfc_h2s.
module half_single_float_converter_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [hsfc_pkg::WordWidth-1:0] bits_in,
    output logic                           done,
    output logic [hsfc_pkg::WordWidth-1:0] bits_out
);

    logic                              in_vld_reg;
    hsfc_pkg::action_t                 action_reg;
    logic [hsfc_pkg::WordWidth-1:0]    bits_reg;
    logic                              done_reg;
    logic [hsfc_pkg::WordWidth-1:0]    bits_out_reg;
    logic [hsfc_pkg::WordWidth-1:0]    bits_out_next;
    logic [hsfc_pkg::HalfWidth-1:0]    half_res;
    logic [hsfc_pkg::WordWidth-1:0]    single_res;
    logic                              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= hsfc_pkg::action_t'(action);
            bits_reg   <= bits_in;
        end
        if (in_vld_reg)
            bits_out_reg <= bits_out_next;
    end

    hsfc_s2h u_s2h
    (
        .src (bits_reg),
        .res (half_res)
    );

    hsfc_h2s u_h2s
    (
        .src (bits_reg[hsfc_pkg::HalfWidth-1:0]),
        .res (single_res)
    );

    always_comb
    begin
        case (action_reg)
            hsfc_pkg::ACT_S2H: bits_out_next = {16'd0, half_res};
            hsfc_pkg::ACT_H2S: bits_out_next = single_res;
            default:           bits_out_next = {16'd0, half_res};
        endcase
    end

    assign done     = done_reg;
    assign bits_out = bits_out_reg;

    // A result strobe follows each accepted word through the input and result registers.
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted word produced no result strobe");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_vld_reg))
        else $error("result strobe without a word in the input stage");

    // Half results carry zeros in the upper half of the word.
    a_half_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && action_reg == hsfc_pkg::ACT_S2H) |=> (bits_out[31:16] == 16'd0))
        else $error("half result has nonzero upper bits");

endmodule

@@ bench/tb_half_single_float_converter_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for half_single_float_converter_top: directed and random
// conversion words in both directions, checked against an in-bench predictor.
// Depends on hsfc_pkg and half_single_float_converter_top.
module tb_half_single_float_converter_top;

    localparam int RandomWords = 900;
    localparam int StallLimit = 2000;
    localparam int DrainCycles = 6;

    // Holds the converted words still owed by the block and predicts new ones.
    class conversion_checker;
        logic [hsfc_pkg::WordWidth-1:0] owed_words[$];
        int error_count = 0;

        function automatic logic [hsfc_pkg::WordWidth-1:0] single_to_half(
            logic [hsfc_pkg::WordWidth-1:0] src);
            logic                                 sign;
            logic [hsfc_pkg::SingleExpWidth-1:0]  exp_field;
            logic [hsfc_pkg::SingleMantWidth-1:0] mant;
            logic [hsfc_pkg::SingleExpWidth-1:0]  rebiased;
            sign = src[31];
            exp_field = src[30:23];
            mant = src[22:0];
            rebiased = exp_field - hsfc_pkg::S2H_EXP_LOW;
            if (exp_field <= hsfc_pkg::S2H_EXP_LOW)
                return {16'h0000, sign, 15'h0000};
            if (exp_field >= hsfc_pkg::S2H_EXP_HIGH)
            begin
                // Only a true NaN keeps the quiet bit; large finite values saturate.
                if (exp_field == hsfc_pkg::S_EXP_ALL && mant != '0)
                    return {16'h0000, sign, hsfc_pkg::H_EXP_ALL, hsfc_pkg::H_QUIET};
                return {16'h0000, sign, hsfc_pkg::H_EXP_ALL, 10'h000};
            end
            return {16'h0000, sign, rebiased[hsfc_pkg::HalfExpWidth-1:0], mant[22:13]};
        endfunction

        function automatic logic [hsfc_pkg::WordWidth-1:0] half_to_single(
            logic [hsfc_pkg::HalfWidth-1:0] src);
            logic                                sign;
            logic [hsfc_pkg::HalfExpWidth-1:0]   exp_field;
            logic [hsfc_pkg::HalfMantWidth-1:0]  mant;
            logic [hsfc_pkg::HalfMantWidth:0]    norm;
            logic [hsfc_pkg::SingleExpWidth-1:0] shifts;
            sign = src[15];
            exp_field = src[14:10];
            mant = src[9:0];
            if (exp_field == '0)
            begin
                if (mant == '0)
                    return {sign, 31'h0};
                norm = {1'b0, mant};
                shifts = '0;
                for (int i = 0; i < 11; i++)
                begin
                    if (norm[hsfc_pkg::HalfMantWidth])
                        break;
                    norm = norm << 1;
                    shifts = shifts + 8'd1;
                end
                return {sign, 8'd113 - shifts, norm[9:0], 13'h0000};
            end
            if (exp_field == hsfc_pkg::H_EXP_ALL)
                return {sign, hsfc_pkg::S_EXP_ALL, mant, 13'h0000};
            return {sign, {3'b000, exp_field} + hsfc_pkg::H2S_BIAS_ADJ, mant, 13'h0000};
        endfunction

        function void note_source(hsfc_pkg::action_t act,
                                  logic [hsfc_pkg::WordWidth-1:0] src);
            if (act == hsfc_pkg::ACT_S2H)
                owed_words.push_back(single_to_half(src));
            else
                owed_words.push_back(half_to_single(src[hsfc_pkg::HalfWidth-1:0]));
        endfunction

        task report(string what, logic [hsfc_pkg::WordWidth-1:0] got,
                    logic [hsfc_pkg::WordWidth-1:0] want);
            error_count++;
            $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        endtask

        task check_converted(logic [hsfc_pkg::WordWidth-1:0] got);
            logic [hsfc_pkg::WordWidth-1:0] want;
            if (owed_words.size() == 0)
            begin
                report("unexpected bits_out", got, '0);
                return;
            end
            want = owed_words.pop_front();
            if (got !== want)
                report("bits_out", got, want);
        endtask

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           action;
    logic [hsfc_pkg::WordWidth-1:0] bits_in;
    logic                           done;
    logic [hsfc_pkg::WordWidth-1:0] bits_out;

    conversion_checker checker_h;
    int idle_cycles = 0;
    int calm_left = 0;

    half_single_float_converter_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .bits_in  (bits_in),
        .done     (done),
        .bits_out (bits_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Accepted words and results are sampled on the rising edge; the watchdog
    // counts edges at which neither side moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                checker_h.note_source(hsfc_pkg::action_t'(action), bits_in);
            if (done)
                checker_h.check_converted(bits_out);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("FAIL half_single_float_converter_top");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_word(hsfc_pkg::action_t act, logic [hsfc_pkg::WordWidth-1:0] src);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        bits_in <= src;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [hsfc_pkg::WordWidth-1:0] random_single();
        logic [hsfc_pkg::WordWidth-1:0] w;
        int roll;
        w = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            ;
        else if (roll < 7)
            w[30:23] = 8'($urandom_range(100, 150));
        else if (roll < 8)
        begin
            w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 3) == 0)
                w[22:0] = '0;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: w[30:23] = 8'd112;
                1: w[30:23] = 8'd113;
                2: w[30:23] = 8'd142;
                default: w[30:23] = 8'd143;
            endcase
        end
        return w;
    endfunction

    function automatic logic [hsfc_pkg::WordWidth-1:0] random_half();
        logic [hsfc_pkg::WordWidth-1:0] w;
        int roll;
        w = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            w[14:10] = '0;
        else if (roll < 4)
        begin
            // Subnormals with a single set bit sweep every normalize distance.
            w[14:10] = '0;
            w[9:0] = 10'h001 << $urandom_range(0, 9);
        end
        else if (roll < 5)
        begin
            w[14:10] = hsfc_pkg::H_EXP_ALL;
            if ($urandom_range(0, 2) == 0)
                w[9:0] = '0;
        end
        return w;
    endfunction

    initial
    begin
        logic [hsfc_pkg::WordWidth-1:0] single_cases[$];
        logic [hsfc_pkg::WordWidth-1:0] half_cases[$];
        checker_h = new;
        rst_n = 1'b0;
        start = 1'b0;
        action = hsfc_pkg::ACT_S2H;
        bits_in = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Zeros, single subnormals, underflow edge, smallest and largest normal
        // half, overflow, infinities and NaNs with and without high payload bits.
        single_cases = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                         32'h3800_0000, 32'h3880_0000, 32'h477F_FFFF, 32'h4780_0000,
                         32'hC7FF_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                         32'hFF80_0001, 32'h7FFF_FFFF};
        // Zeros, smallest and largest subnormal, normals, infinities, NaNs and
        // upper bits that must be ignored.
        half_cases = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF,
                       32'h0000_8200, 32'h0000_0400, 32'h0000_7BFF, 32'h0000_7C00,
                       32'h0000_FC00, 32'h0000_7E00, 32'hABCD_7C01, 32'hFFFF_FFFF};
        foreach (single_cases[i])
            send_word(hsfc_pkg::ACT_S2H, single_cases[i]);
        foreach (half_cases[i])
            send_word(hsfc_pkg::ACT_H2S, half_cases[i]);

        for (int n = 0; n < RandomWords; n++)
        begin
            if ($urandom_range(0, 1))
                send_word(hsfc_pkg::ACT_H2S, random_half());
            else
                send_word(hsfc_pkg::ACT_S2H, random_single());
        end
        @(negedge clk);
        start <= 1'b0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (checker_h.error_count == 0)
            $display("PASS half_single_float_converter_top");
        else
            $display("FAIL half_single_float_converter_top");
        $finish;
    end

endmodule
